/* design/csv_line_alert_filter_defines.svh */
// Assertion macros used by the filter's top module.
`ifndef CSV_LINE_ALERT_FILTER_DEFINES_SVH
`define CSV_LINE_ALERT_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge, ignored while reset is asserted
`define CSVLAF_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: %s failed", "name");
// Checked on every rising edge, reset included
`define CSVLAF_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("%m: %s failed", "name");
`else
`define CSVLAF_ASSERT(name, clk, rst_n, prop)
`define CSVLAF_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* design/csvlaf_pkg.sv */
package csvlaf_pkg;

	// Default sizing
	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_COUNT_WIDTH = 16;

	// Configuration register indexes
	localparam logic [2:0] REG_STATUS_COL   = 3'd0;
	localparam logic [2:0] REG_LABEL_COL    = 3'd1;
	localparam logic [2:0] REG_ATTEMPTS_COL = 3'd2;
	localparam logic [2:0] REG_COMMENT_COL  = 3'd3;
	localparam logic [2:0] REG_THRESHOLD    = 3'd4;

	// Register reset values
	localparam logic [6:0]  COL_ABSENT    = 7'h7F;
	localparam logic [15:0] THRESHOLD_RST = 16'd5;

	// Special bytes
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_COMMA   = 8'd44;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;

	// Reason codes
	localparam logic [2:0] RSN_NONE     = 3'd0;
	localparam logic [2:0] RSN_STATUS   = 3'd1;
	localparam logic [2:0] RSN_LABEL    = 3'd2;
	localparam logic [2:0] RSN_ATTEMPTS = 3'd3;
	localparam logic [2:0] RSN_COMMENT  = 3'd4;

	// Attempts digit run tracking
	localparam logic [1:0] DIG_NONE = 2'd0;
	localparam logic [1:0] DIG_RUN  = 2'd1;
	localparam logic [1:0] DIG_DONE = 2'd2;

	// Exact words, six letters each
	localparam int WORD_LEN = 6;
	localparam logic [7:0] STATUS_WORD [WORD_LEN] = '{"f", "a", "i", "l", "e", "d"};
	localparam logic [7:0] LABEL_WORD  [WORD_LEN] = '{"n", "o", "r", "m", "a", "l"};

	// Comment keywords, padded with zeros
	localparam int NUM_KW    = 4;
	localparam int KW_MAXLEN = 9;
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXLEN] = '{
		'{"b", "r", "u", "t", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "c", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"g", "e", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"p", "r", "i", "v", "i", "l", "e", "g", "e"}
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd5, 4'd4, 4'd3, 4'd9};

	// Register set seen by the scanner
	typedef struct packed {
		logic [6:0]  status_col;
		logic [6:0]  label_col;
		logic [6:0]  attempts_col;
		logic [6:0]  comment_col;
		logic [15:0] threshold;
	} cfg_t;

	// Line verdict from the scanner
	typedef struct packed {
		logic       valid;
		logic       suspicious;
		logic [2:0] reason;
	} res_t;

endpackage

/* design/csvlaf_cfg.sv */
module csvlaf_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output csvlaf_pkg::cfg_t   cfg
);
	import csvlaf_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.status_col   <= COL_ABSENT;
			cfg_q.label_col    <= COL_ABSENT;
			cfg_q.attempts_col <= COL_ABSENT;
			cfg_q.comment_col  <= COL_ABSENT;
			cfg_q.threshold    <= THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_STATUS_COL:   cfg_q.status_col   <= pwdata[6:0];
				REG_LABEL_COL:    cfg_q.label_col    <= pwdata[6:0];
				REG_ATTEMPTS_COL: cfg_q.attempts_col <= pwdata[6:0];
				REG_COMMENT_COL:  cfg_q.comment_col  <= pwdata[6:0];
				REG_THRESHOLD:    cfg_q.threshold    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_STATUS_COL:   prdata = {25'd0, cfg_q.status_col};
			REG_LABEL_COL:    prdata = {25'd0, cfg_q.label_col};
			REG_ATTEMPTS_COL: prdata = {25'd0, cfg_q.attempts_col};
			REG_COMMENT_COL:  prdata = {25'd0, cfg_q.comment_col};
			REG_THRESHOLD:    prdata = {16'd0, cfg_q.threshold};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

/* design/csvlaf_scan.sv */
module csvlaf_scan #(
	parameter int MAX_COLUMNS = csvlaf_pkg::DEF_MAX_COLUMNS,
	parameter int COUNT_WIDTH = csvlaf_pkg::DEF_COUNT_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_byte,
	input  csvlaf_pkg::cfg_t  cfg,
	output csvlaf_pkg::res_t  res
);
	import csvlaf_pkg::*;

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
	localparam int ATT_W = COUNT_WIDTH + 4;
	localparam int THR_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [ATT_W-1:0] ATT_MAX = ATT_W'({COUNT_WIDTH{1'b1}});

	// Line state
	logic [CNT_W-1:0]       col_cnt_q, col_cnt_d;
	logic                   nonempty_q, nonempty_d;
	logic [2:0]             st_pos_q, st_pos_d;
	logic                   st_bad_q, st_bad_d;
	logic [2:0]             lb_pos_q, lb_pos_d;
	logic                   lb_bad_q, lb_bad_d;
	logic                   lb_bytes_q, lb_bytes_d;
	logic [COUNT_WIDTH-1:0] att_val_q, att_val_d;
	logic [1:0]             att_state_q, att_state_d;
	logic [3:0]             kw_pos_q [NUM_KW];
	logic [3:0]             kw_pos_d [NUM_KW];
	logic                   kw_hit_q, kw_hit_d;

	logic [7:0]       lc;
	logic             is_nl, is_comma, is_digit;
	logic             in_status, in_label, in_attempts, in_comment;
	logic [ATT_W-1:0] att_next;

	// Column select: negative index means the column is absent
	function automatic logic col_hit(input logic [6:0] col, input logic [CNT_W-1:0] cnt);
		return !col[6] && (CMP_W'(col[5:0]) == CMP_W'(cnt));
	endfunction

	// Letter of a six-letter word, zero past its end
	function automatic logic [7:0] word_at(input logic is_status, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (pos < 3'(WORD_LEN))
			ch = is_status ? STATUS_WORD[pos] : LABEL_WORD[pos];
		return ch;
	endfunction

	function automatic logic [7:0] kw_at(input int k, input logic [3:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (pos < 4'(KW_MAXLEN))
			ch = KW_TEXT[k][pos];
		return ch;
	endfunction

	// ASCII fold to lower case
	assign lc = (char_byte >= CH_UPPER_A && char_byte <= CH_UPPER_Z) ?
		(char_byte | 8'h20) : char_byte;

	assign is_nl    = (char_byte == CH_NEWLINE);
	assign is_comma = (char_byte == CH_COMMA);
	assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);

	assign in_status   = col_hit(cfg.status_col, col_cnt_q);
	assign in_label    = col_hit(cfg.label_col, col_cnt_q);
	assign in_attempts = col_hit(cfg.attempts_col, col_cnt_q);
	assign in_comment  = col_hit(cfg.comment_col, col_cnt_q);

	// value * 10 + digit
	assign att_next = (ATT_W'(att_val_q) << 3) + (ATT_W'(att_val_q) << 1) +
		ATT_W'(char_byte[3:0]);

	// Verdict at the end of a line, first reason that holds
	always_comb begin
		res.valid  = nonempty_q && is_nl;
		res.reason = RSN_NONE;
		if (!st_bad_q && st_pos_q == 3'(WORD_LEN))
			res.reason = RSN_STATUS;
		else if (lb_bytes_q && !(!lb_bad_q && lb_pos_q == 3'(WORD_LEN)))
			res.reason = RSN_LABEL;
		else if (!cfg.attempts_col[6] &&
				THR_W'(att_val_q) >= THR_W'(cfg.threshold))
			res.reason = RSN_ATTEMPTS;
		else if (kw_hit_q)
			res.reason = RSN_COMMENT;
		res.suspicious = (res.reason != RSN_NONE);
	end

	// Next line state
	always_comb begin
		logic [3:0] p;
		col_cnt_d   = col_cnt_q;
		nonempty_d  = nonempty_q;
		st_pos_d    = st_pos_q;
		st_bad_d    = st_bad_q;
		lb_pos_d    = lb_pos_q;
		lb_bad_d    = lb_bad_q;
		lb_bytes_d  = lb_bytes_q;
		att_val_d   = att_val_q;
		att_state_d = att_state_q;
		kw_pos_d    = kw_pos_q;
		kw_hit_d    = kw_hit_q;
		p           = 4'd0;

		if (is_nl) begin
			col_cnt_d   = '0;
			nonempty_d  = 1'b0;
			st_pos_d    = 3'd0;
			st_bad_d    = 1'b0;
			lb_pos_d    = 3'd0;
			lb_bad_d    = 1'b0;
			lb_bytes_d  = 1'b0;
			att_val_d   = '0;
			att_state_d = DIG_NONE;
			for (int k = 0; k < NUM_KW; k++)
				kw_pos_d[k] = 4'd0;
			kw_hit_d    = 1'b0;
		end else if (is_comma) begin
			nonempty_d = 1'b1;
			for (int k = 0; k < NUM_KW; k++)
				kw_pos_d[k] = 4'd0;
			if (col_cnt_q < CNT_W'(MAX_COLUMNS))
				col_cnt_d = col_cnt_q + 1'b1;
		end else begin
			nonempty_d = 1'b1;

			// status word
			if (in_status && !st_bad_q) begin
				if (st_pos_q < 3'(WORD_LEN) && lc == word_at(1'b1, st_pos_q))
					st_pos_d = st_pos_q + 3'd1;
				else
					st_bad_d = 1'b1;
			end

			// label word
			if (in_label) begin
				lb_bytes_d = 1'b1;
				if (!lb_bad_q) begin
					if (lb_pos_q < 3'(WORD_LEN) && lc == word_at(1'b0, lb_pos_q))
						lb_pos_d = lb_pos_q + 3'd1;
					else
						lb_bad_d = 1'b1;
				end
			end

			// first digit run, saturating
			if (in_attempts) begin
				if (is_digit && att_state_q != DIG_DONE) begin
					att_val_d   = (att_next > ATT_MAX) ? {COUNT_WIDTH{1'b1}} :
						att_next[COUNT_WIDTH-1:0];
					att_state_d = DIG_RUN;
				end else if (!is_digit && att_state_q == DIG_RUN) begin
					att_state_d = DIG_DONE;
				end
			end

			// keyword search; no keyword repeats its first letter
			if (in_comment) begin
				for (int k = 0; k < NUM_KW; k++) begin
					p = kw_pos_q[k];
					if (p < KW_LEN[k] && lc == kw_at(k, p))
						p = p + 4'd1;
					else
						p = (lc == KW_TEXT[k][0]) ? 4'd1 : 4'd0;
					if (p >= KW_LEN[k]) begin
						kw_hit_d = 1'b1;
						p = 4'd0;
					end
					kw_pos_d[k] = p;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q   <= '0;
			nonempty_q  <= 1'b0;
			st_pos_q    <= 3'd0;
			st_bad_q    <= 1'b0;
			lb_pos_q    <= 3'd0;
			lb_bad_q    <= 1'b0;
			lb_bytes_q  <= 1'b0;
			att_val_q   <= '0;
			att_state_q <= DIG_NONE;
			for (int k = 0; k < NUM_KW; k++)
				kw_pos_q[k] <= 4'd0;
			kw_hit_q    <= 1'b0;
		end else if (step) begin
			col_cnt_q   <= col_cnt_d;
			nonempty_q  <= nonempty_d;
			st_pos_q    <= st_pos_d;
			st_bad_q    <= st_bad_d;
			lb_pos_q    <= lb_pos_d;
			lb_bad_q    <= lb_bad_d;
			lb_bytes_q  <= lb_bytes_d;
			att_val_q   <= att_val_d;
			att_state_q <= att_state_d;
			kw_pos_q    <= kw_pos_d;
			kw_hit_q    <= kw_hit_d;
		end
	end

endmodule

/* design/csv_line_alert_filter.sv */
// CSV line alert filter.
// Input stream: one line byte per transaction on s_tdata[7:0]. A newline ends
// a line, a comma ends a column. Output stream: one transaction per finished
// non-empty line carrying the suspicious flag and the first reason found.
// Column indexes and the attempts threshold are set over the APB port and
// should only be changed while no line is in flight.
// Throughput: one byte per cycle unless a verdict finds the result register
// full, set by the update of the per-line match state in the scanner. A byte
// is scanned while it sits in the input register; a newline's verdict enters
// the result register (m_tvalid) as the newline leaves the input register.
// Reset clears the line state, empties both registers and returns every
// column index to absent and the threshold to 5.
// If the receiver stalls, the verdict is held while the bytes of the next
// line keep flowing; a newline that would give the next verdict waits in the
// input register and s_tready drops until m_tready returns, so no
// transaction is lost.
`include "csv_line_alert_filter_defines.svh"

module csv_line_alert_filter #(
	parameter int MAX_COLUMNS = csvlaf_pkg::DEF_MAX_COLUMNS,
	parameter int COUNT_WIDTH = csvlaf_pkg::DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] suspicious, [3:1] reason, [7:4] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import csvlaf_pkg::*;

	cfg_t       cfg;
	res_t       scan_res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       res_valid_q;
	logic       res_susp_q;
	logic [2:0] res_reason_q;

	// Register block
	csvlaf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Byte leaves the input register unless its verdict finds the result register full and not being taken
	assign adv      = valid_s1 && (!scan_res.valid || !res_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	// Line scanner
	csvlaf_scan #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.char_byte (byte_s1),
		.cfg       (cfg),
		.res       (scan_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && scan_res.valid) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && scan_res.valid) begin
			res_susp_q   <= scan_res.suspicious;
			res_reason_q <= scan_res.reason;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {4'd0, res_reason_q, res_susp_q};

	// Checks
	`CSVLAF_ASSERT(a_ready_when_empty, clk, arst_n, !valid_s1 |-> s_tready)
	`CSVLAF_ASSERT(a_verdict_from_newline, clk, arst_n,
		adv && scan_res.valid |-> byte_s1 == CH_NEWLINE)
	`CSVLAF_ASSERT(a_result_loaded_by_scan, clk, arst_n,
		$rose(res_valid_q) |-> $past(adv && scan_res.valid))
	`CSVLAF_ASSERT(a_flag_matches_reason, clk, arst_n,
		m_tvalid |-> (res_susp_q == (res_reason_q != RSN_NONE)) &&
		(res_reason_q <= RSN_COMMENT))
	`CSVLAF_ASSERT_ALWAYS(a_empty_in_reset, clk, !arst_n |-> !m_tvalid)

endmodule
